### design/sitoa_pkg.sv
// sitoa_pkg: shared types, constants and helper functions for the signed
// integer to ascii digits unit; no dependencies
package sitoa_pkg;

  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } sitoa_state_e;

  // saturate the base into 2..16
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // digit value to ascii, 10..15 map to upper case letters
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
    end else begin
      res = CH_ALPHA + {{(CHAR_W-DIGIT_W){1'b0}}, d - 4'd10};
    end
    return res;
  endfunction

endpackage

### design/sitoa_intf.sv
// sitoa channel interfaces: number input, character output, base write
// depends on sitoa_pkg for the fixed field widths

interface sitoa_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
  logic                           valid;
  logic                           ready;
  logic [sitoa_pkg::CHAR_W-1:0]   character;
  logic                           last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface sitoa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sitoa_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

### design/signed_integer_to_ascii_digits_unit.sv
// signed_integer_to_ascii_digits_unit: signed number to ascii text in base 2..16
// depends on sitoa_pkg and the channel interfaces in sitoa_intf.sv
//
//   channel | dir | payload             | transaction when
//   --------+-----+---------------------+---------------------
//   in_i    | in  | value               | in_i.valid & in_i.ready
//   cfg_i   | in  | radix               | cfg_i.valid (always ready)
//   out_o   | out | character, last     | out_o.valid & out_o.ready
//
// one number at a time; the bit-serial divider works through all VALUE_BITS
// magnitude bits for each digit, then the unit emits the minus sign if the
// number is negative and, for each character, reads the store and emits it
// reset clears control state and sets the base to ten; the digit store has none
// a stalled output holds the sign and emit states; only a waiting last
// character lets the next number's division run on
module signed_integer_to_ascii_digits_unit #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sitoa_in_if.sink     in_i,
  sitoa_cfg_if.sink    cfg_i,
  sitoa_out_if.source  out_o
);
  import sitoa_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VALUE_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // control state
  sitoa_state_e     state_q, state_d;
  logic [RADIX_W-1:0] radix_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic             neg_q, neg_d;
  logic             ov_q, ov_d;

  // datapath
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [CHAR_W-1:0]     ch_q, ch_d;
  logic                  last_q, last_d;

  // digit store, one write and one registered read port
  logic [DIGIT_W-1:0] store_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_q;
  logic               st_we, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;

  // divider step signals
  logic [RADIX_W-1:0]    radix_eff;
  logic [RADIX_W-1:0]    trial;
  logic                  qbit;
  logic [RADIX_W-1:0]    rem_next;
  logic [VALUE_BITS-1:0] quo_next;
  logic                  out_free;
  logic                  in_fire;
  logic [VALUE_BITS-1:0] in_val;

  assign radix_eff = clamp_radix(radix_q);
  assign in_val    = in_i.value;

  // one restoring-division bit: bring in the next magnitude bit
  assign trial    = {rem_q, mag_q[VALUE_BITS-1]};
  assign qbit     = (trial >= radix_eff);
  assign rem_next = qbit ? (trial - radix_eff) : trial;
  assign quo_next = {mag_q[VALUE_BITS-2:0], qbit};

  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign out_free     = !ov_q || out_o.ready;

  assign out_o.valid     = ov_q;
  assign out_o.character = ch_q;
  assign out_o.last      = last_q;

  assign wr_addr = cnt_q[IDX_W-1:0];
  assign rd_addr = IDX_W'(cnt_q - CNT_ONE);

  // next state and datapath control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    ov_d    = ov_q && !out_o.ready;
    ch_d    = ch_q;
    last_d  = last_q;
    st_we   = 1'b0;
    rd_en   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          neg_d   = in_val[VALUE_BITS-1];
          mag_d   = in_val[VALUE_BITS-1] ? (~in_val + 1'b1) : in_val;
          rem_d   = '0;
          bit_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        mag_d = quo_next;
        rem_d = rem_next[DIGIT_W-1:0];
        bit_d = bit_q + 1'b1;
        if (bit_q == BIT_LAST) begin
          // digit done: store remainder, restart on the quotient
          st_we = 1'b1;
          cnt_d = cnt_q + CNT_ONE;
          bit_d = '0;
          rem_d = '0;
          if (quo_next == '0 || cnt_d == CNT_FULL) begin
            state_d = neg_q ? ST_SIGN : ST_FETCH;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ch_d    = CH_MINUS;
          last_d  = 1'b0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ch_d    = digit_char(rd_q);
          last_d  = (cnt_q == CNT_ONE);
          cnt_d   = cnt_q - CNT_ONE;
          state_d = (cnt_q == CNT_ONE) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      radix_q <= RADIX_RESET;
      cnt_q   <= '0;
      bit_q   <= '0;
      neg_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      neg_q   <= neg_d;
      ov_q    <= ov_d;
      if (cfg_i.valid && cfg_i.ready) begin
        radix_q <= cfg_i.radix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[wr_addr] <= rem_next[DIGIT_W-1:0];
    end
    if (rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  // a new number always starts a fresh division with an empty store
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_DIVIDE) && (cnt_q == '0) && (bit_q == '0))
    else $error("division did not start clean");

  // partial remainder stays below the base
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> ({1'b0, rem_q} < radix_eff))
    else $error("remainder not below base");

  // emitting a digit needs one in the store
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT || state_q == ST_FETCH) |-> (cnt_q != '0))
    else $error("digit emit with empty store");

  // digit count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("digit count overflow");

endmodule
